### design/sli_pkg.sv
// Shared types, constants and arithmetic helpers of the segment line intersect unit.
// No dependencies; every other design file imports this package.
`default_nettype none
package sli_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XY_W      = 32;
    localparam int Q_W       = XY_W + 1;
    localparam int PROD_W    = 2 * XY_W;
    localparam int IC_W      = PROD_W - FRAC_BITS + 2;
    localparam int DIFF_W    = IC_W + 1;
    localparam int DVD_W     = DIFF_W + FRAC_BITS;
    localparam int DVS_W     = DVD_W - Q_W;
    localparam int SIDE_W    = 4 * XY_W + 2;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_DISJOINT = 2'd2;
    localparam logic [1:0] ST_VERTICAL = 2'd3;

    localparam logic [Q_W-1:0] Q_HALF = {1'b0, 1'b1, {(Q_W-2){1'b0}}};
    localparam logic signed [XY_W-1:0] S_MAX = {1'b0, {(XY_W-1){1'b1}}};
    localparam logic signed [XY_W-1:0] S_MIN = {1'b1, {(XY_W-1){1'b0}}};

    typedef struct packed {
        logic [DVS_W-1:0]  rem;
        logic [Q_W-1:0]    dvd_lo;
        logic [DVS_W-1:0]  dvs;
        logic [Q_W-1:0]    quo;
        logic              neg;
        logic              ovf;
        logic [SIDE_W-1:0] side;
    } t_div_data;

    // Magnitude of a coordinate difference.
    function automatic logic [Q_W-1:0] mag33(input logic signed [Q_W-1:0] v);
        mag33 = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
    endfunction

    // Turn an unsigned quotient with sign and overflow into a saturated signed word.
    function automatic logic signed [XY_W-1:0] sat_quo(input logic [Q_W-1:0] q,
                                                       input logic ovf, input logic neg);
        logic [Q_W-1:0] nq;
        nq = -q;
        if (ovf) begin
            sat_quo = neg ? S_MIN : S_MAX;
        end else if (neg) begin
            sat_quo = (q > Q_HALF) ? S_MIN : nq[XY_W-1:0];
        end else begin
            sat_quo = (q >= Q_HALF) ? S_MAX : q[XY_W-1:0];
        end
    endfunction

    // Saturate a wide signed sum to a signed word.
    function automatic logic signed [XY_W-1:0] sat_wide(input logic signed [PROD_W:0] v);
        if (v > (PROD_W+1)'(S_MAX)) begin
            sat_wide = S_MAX;
        end else if (v < (PROD_W+1)'(S_MIN)) begin
            sat_wide = S_MIN;
        end else begin
            sat_wide = v[XY_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

### design/segment_line_intersect_unit.sv
// Top level of the segment line intersect unit: input registers, two slope dividers,
// intercept stages, crossing divider and output register. Depends on sli_pkg, sli_div_chain.
//
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one request of two segments, each as
//   start and end points in signed Q16.16. Output channel: o_out_valid / i_out_ready
//   carry one result per request: o_status (0 hit, 1 parallel, 2 boxes disjoint,
//   3 vertical or degenerate) and the crossing point o_cross_x / o_cross_y, zero
//   unless the status is hit.
//   Throughput: one request per cycle while the receiver takes results.
//   Pipeline: from acceptance to the output, a result passes the input registers, two
//   restoring-division chains in series, slope then crossing, each a load stage plus
//   33 cells (one per quotient bit), the two 32x32 multiply stages, the intercept
//   stage, the slope and crossing saturation stages and the output register.
//   Every stage advances together; when the output holds a result that the receiver
//   does not take, the whole pipeline holds and o_in_ready drops, so nothing is lost.
//   Reset (synchronous, active low) clears all valid bits; no result is pending after it.
//   Each request yields exactly one result, in order.
`default_nettype none
module segment_line_intersect_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire signed [31:0]  i_seg_a_start_x,
    input  wire signed [31:0]  i_seg_a_start_y,
    input  wire signed [31:0]  i_seg_a_end_x,
    input  wire signed [31:0]  i_seg_a_end_y,
    input  wire signed [31:0]  i_seg_b_start_x,
    input  wire signed [31:0]  i_seg_b_start_y,
    input  wire signed [31:0]  i_seg_b_end_x,
    input  wire signed [31:0]  i_seg_b_end_y,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_cross_x,
    output logic signed [31:0] o_cross_y
);
    import sli_pkg::*;

    logic adv;

    // Input registers.
    logic                   r_in_v;
    logic signed [XY_W-1:0] r_ax1, r_ay1, r_ax2, r_ay2, r_bx1, r_by1, r_bx2, r_by2;

    // Slope divider inputs.
    logic signed [Q_W-1:0]  dax, day, dbx, dby;
    logic                   degen, disjoint;
    logic [DVD_W-1:0]       a_dvd, b_dvd;
    logic [DVS_W-1:0]       a_dvs, b_dvs;
    logic [SIDE_W-1:0]      a_side;
    logic signed [XY_W-1:0] amax_x, amin_x, bmax_x, bmin_x;
    logic signed [XY_W-1:0] amax_y, amin_y, bmax_y, bmin_y;

    logic      a_v, b_v;
    t_div_data a_q, b_q;

    // Post slope stages.
    logic                   r_p1_v, r_p1_degen, r_p1_disj;
    logic signed [XY_W-1:0] r_p1_ma, r_p1_mb, r_p1_ax1, r_p1_ay1, r_p1_bx1, r_p1_by1;
    logic                   r_p2_v;
    logic signed [PROD_W-1:0] r_p2_pa, r_p2_pb;
    logic signed [XY_W-1:0] r_p2_ma, r_p2_mb, r_p2_ay1, r_p2_by1;
    logic [1:0]             r_p2_st, n_p2_st;
    logic                   r_p3_v;
    logic signed [IC_W-1:0] r_p3_ba, r_p3_bb;
    logic signed [XY_W-1:0] r_p3_ma, r_p3_mb;
    logic [1:0]             r_p3_st;

    // Crossing divider inputs.
    logic signed [DIFF_W-1:0] cn;
    logic signed [Q_W-1:0]    cd;
    logic [DIFF_W-1:0]        cn_mag;
    logic [DVD_W-1:0]         c_dvd;
    logic [DVS_W-1:0]         c_dvs;
    logic [SIDE_W-1:0]        c_side;
    logic                     c_v;
    t_div_data                c_q;

    // Post crossing stages.
    logic                     r_p5_v;
    logic signed [XY_W-1:0]   r_p5_cx, r_p5_ma;
    logic signed [IC_W-1:0]   r_p5_ba;
    logic [1:0]               r_p5_st;
    logic                     r_p6_v;
    logic signed [PROD_W-1:0] r_p6_pc;
    logic signed [XY_W-1:0]   r_p6_cx;
    logic signed [IC_W-1:0]   r_p6_ba;
    logic [1:0]               r_p6_st;
    logic signed [PROD_W:0]   cy_sum;

    logic                     r_out_v;
    logic [1:0]               r_out_st;
    logic signed [XY_W-1:0]   r_out_cx, r_out_cy;

    // Advance every stage together unless a finished result is held.
    assign adv        = !r_out_v || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_p6_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_in_v  <= i_in_valid;
            r_p1_v  <= a_v && b_v;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p5_v  <= c_v;
            r_p6_v  <= r_p5_v;
            r_out_v <= r_p6_v;
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax1 <= i_seg_a_start_x;
            r_ay1 <= i_seg_a_start_y;
            r_ax2 <= i_seg_a_end_x;
            r_ay2 <= i_seg_a_end_y;
            r_bx1 <= i_seg_b_start_x;
            r_by1 <= i_seg_b_start_y;
            r_bx2 <= i_seg_b_end_x;
            r_by2 <= i_seg_b_end_y;
        end
    end

    // Differences, degenerate check and bounding boxes.
    always_comb begin
        dax = Q_W'(r_ax2) - Q_W'(r_ax1);
        day = Q_W'(r_ay2) - Q_W'(r_ay1);
        dbx = Q_W'(r_bx2) - Q_W'(r_bx1);
        dby = Q_W'(r_by2) - Q_W'(r_by1);
        degen = (r_ax1 == r_ax2) || (r_bx1 == r_bx2);

        amax_x = (r_ax1 > r_ax2) ? r_ax1 : r_ax2;
        amin_x = (r_ax1 > r_ax2) ? r_ax2 : r_ax1;
        bmax_x = (r_bx1 > r_bx2) ? r_bx1 : r_bx2;
        bmin_x = (r_bx1 > r_bx2) ? r_bx2 : r_bx1;
        amax_y = (r_ay1 > r_ay2) ? r_ay1 : r_ay2;
        amin_y = (r_ay1 > r_ay2) ? r_ay2 : r_ay1;
        bmax_y = (r_by1 > r_by2) ? r_by1 : r_by2;
        bmin_y = (r_by1 > r_by2) ? r_by2 : r_by1;
        // Touching boxes still overlap.
        disjoint = (amax_x < bmin_x) || (bmax_x < amin_x) ||
                   (amax_y < bmin_y) || (bmax_y < amin_y);

        a_dvd  = DVD_W'(mag33(day)) << FRAC_BITS;
        a_dvs  = DVS_W'(mag33(dax));
        b_dvd  = DVD_W'(mag33(dby)) << FRAC_BITS;
        b_dvs  = DVS_W'(mag33(dbx));
        a_side = {r_ax1, r_ay1, r_bx1, r_by1, degen, disjoint};
    end

    // Slope of segment A; it carries the points and flags alongside.
    sli_div_chain u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_in_v),
        .i_dvd   (a_dvd),
        .i_dvs   (a_dvs),
        .i_neg   (dax[Q_W-1] ^ day[Q_W-1]),
        .i_side  (a_side),
        .o_valid (a_v),
        .o_data  (a_q)
    );

    // Slope of segment B, in lockstep with A.
    sli_div_chain u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_in_v),
        .i_dvd   (b_dvd),
        .i_dvs   (b_dvs),
        .i_neg   (dbx[Q_W-1] ^ dby[Q_W-1]),
        .i_side  ('0),
        .o_valid (b_v),
        .o_data  (b_q)
    );

    // Saturate slopes and unpack the side band.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_ma    <= sat_quo(a_q.quo, a_q.ovf, a_q.neg);
            r_p1_mb    <= sat_quo(b_q.quo, b_q.ovf, b_q.neg);
            r_p1_ax1   <= a_q.side[4*XY_W+1 -: XY_W];
            r_p1_ay1   <= a_q.side[3*XY_W+1 -: XY_W];
            r_p1_bx1   <= a_q.side[2*XY_W+1 -: XY_W];
            r_p1_by1   <= a_q.side[XY_W+1 -: XY_W];
            r_p1_degen <= a_q.side[1];
            r_p1_disj  <= a_q.side[0];
        end
    end

    // Status in priority order: degenerate, parallel, disjoint.
    always_comb begin
        priority if (r_p1_degen) begin
            n_p2_st = ST_VERTICAL;
        end else if (r_p1_ma == r_p1_mb) begin
            n_p2_st = ST_PARALLEL;
        end else if (r_p1_disj) begin
            n_p2_st = ST_DISJOINT;
        end else begin
            n_p2_st = ST_HIT;
        end
    end

    // Slope times start x.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_pa  <= r_p1_ma * r_p1_ax1;
            r_p2_pb  <= r_p1_mb * r_p1_bx1;
            r_p2_ma  <= r_p1_ma;
            r_p2_mb  <= r_p1_mb;
            r_p2_ay1 <= r_p1_ay1;
            r_p2_by1 <= r_p1_by1;
            r_p2_st  <= n_p2_st;
        end
    end

    // Intercepts at full width, floor shift.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_ba <= IC_W'(r_p2_ay1) - IC_W'(r_p2_pa >>> FRAC_BITS);
            r_p3_bb <= IC_W'(r_p2_by1) - IC_W'(r_p2_pb >>> FRAC_BITS);
            r_p3_ma <= r_p2_ma;
            r_p3_mb <= r_p2_mb;
            r_p3_st <= r_p2_st;
        end
    end

    // Crossing x = (bb - ba) * 2^F / (ma - mb).
    always_comb begin
        cn     = DIFF_W'(r_p3_bb) - DIFF_W'(r_p3_ba);
        cd     = Q_W'(r_p3_ma) - Q_W'(r_p3_mb);
        cn_mag = cn[DIFF_W-1] ? DIFF_W'(-cn) : DIFF_W'(cn);
        c_dvd  = DVD_W'(cn_mag) << FRAC_BITS;
        c_dvs  = DVS_W'(mag33(cd));
        c_side = SIDE_W'({r_p3_ma, r_p3_ba, r_p3_st});
    end

    sli_div_chain u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_p3_v),
        .i_dvd   (c_dvd),
        .i_dvs   (c_dvs),
        .i_neg   (cn[DIFF_W-1] ^ cd[Q_W-1]),
        .i_side  (c_side),
        .o_valid (c_v),
        .o_data  (c_q)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5_cx <= sat_quo(c_q.quo, c_q.ovf, c_q.neg);
            r_p5_st <= c_q.side[1:0];
            r_p5_ba <= c_q.side[IC_W+1:2];
            r_p5_ma <= c_q.side[IC_W+XY_W+1:IC_W+2];
        end
    end

    // Slope A times crossing x.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p6_pc <= r_p5_ma * r_p5_cx;
            r_p6_cx <= r_p5_cx;
            r_p6_ba <= r_p5_ba;
            r_p6_st <= r_p5_st;
        end
    end

    assign cy_sum = (PROD_W+1)'(r_p6_pc >>> FRAC_BITS) + (PROD_W+1)'(r_p6_ba);

    // Output register; drop the point unless it is a hit.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_st <= r_p6_st;
            r_out_cx <= (r_p6_st == ST_HIT) ? r_p6_cx : '0;
            r_out_cy <= (r_p6_st == ST_HIT) ? sat_wide(cy_sum) : '0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_status    = r_out_st;
    assign o_cross_x   = r_out_cx;
    assign o_cross_y   = r_out_cy;
endmodule
`default_nettype wire

### design/sli_div_cell.sv
// One restoring-division cell: retires one quotient bit per cycle while i_adv is high.
// Depends on sli_pkg.
`default_nettype none
module sli_div_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire                 i_valid,
    input  sli_pkg::t_div_data  i_data,
    output logic                o_valid,
    output sli_pkg::t_div_data  o_data
);
    import sli_pkg::*;

    logic             r_valid;
    t_div_data        r_data;
    t_div_data        n_data;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb begin
        trial  = {i_data.rem, i_data.dvd_lo[Q_W-1]};
        ge     = trial >= {1'b0, i_data.dvs};
        n_data = i_data;
        n_data.rem    = ge ? DVS_W'(trial - {1'b0, i_data.dvs}) : trial[DVS_W-1:0];
        n_data.dvd_lo = {i_data.dvd_lo[Q_W-2:0], 1'b0};
        n_data.quo    = {i_data.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### design/sli_div_chain.sv
// Divider chain: a load stage with overflow check followed by a row of division cells.
// Depends on sli_pkg and sli_div_cell.
`default_nettype none
module sli_div_chain (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  wire                          i_valid,
    input  wire [sli_pkg::DVD_W-1:0]     i_dvd,
    input  wire [sli_pkg::DVS_W-1:0]     i_dvs,
    input  wire                          i_neg,
    input  wire [sli_pkg::SIDE_W-1:0]    i_side,
    output logic                         o_valid,
    output sli_pkg::t_div_data           o_data
);
    import sli_pkg::*;

    logic      st_valid [0:Q_W];
    t_div_data st_data  [0:Q_W];
    logic      r_valid;
    t_div_data r_data;

    // Load: upper dividend bits form the first partial remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data.rem    <= i_dvd[DVD_W-1:Q_W];
            r_data.dvd_lo <= i_dvd[Q_W-1:0];
            r_data.dvs    <= i_dvs;
            r_data.quo    <= '0;
            r_data.neg    <= i_neg;
            r_data.ovf    <= i_dvd[DVD_W-1:Q_W] >= i_dvs;
            r_data.side   <= i_side;
        end
    end

    assign st_valid[0] = r_valid;
    assign st_data[0]  = r_data;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        sli_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_valid (st_valid[g]),
            .i_data  (st_data[g]),
            .o_valid (st_valid[g+1]),
            .o_data  (st_data[g+1])
        );
    end

    assign o_valid = st_valid[Q_W];
    assign o_data  = st_data[Q_W];
endmodule
`default_nettype wire
